// ===== sv/avdf_pkg.sv =====
`default_nettype none
package avdf_pkg;

  localparam int GAIN_ENTRIES = 9;
  localparam logic [3:0] GAIN_LAST_IDX = 4'(GAIN_ENTRIES - 1);

  // Register indexes on the configuration port
  localparam logic [1:0] REG_VOLUME = 2'd0;
  localparam logic [1:0] REG_SINK   = 2'd1;
  localparam logic [1:0] REG_MUTE   = 2'd2;

  // sink_mode codes
  localparam logic SINK_SPEAKER = 1'b0;
  localparam logic SINK_DAC     = 1'b1;

  localparam logic [3:0] VOLUME_RESET = 4'd3;

  localparam int SPK_MAGNITUDE = 254;
  localparam int SPK_HALF      = 127;
  localparam logic [7:0] SPK_BIAS = 8'h80;

  // floor(x / 125) = (x * RECIP_125) >> RECIP_SHIFT, exact for x < 2**22
  localparam int COEF_W      = 18;
  localparam int PROD_W      = 34;
  localparam int RED_W       = 22;
  localparam int RECIP_W     = 23;
  localparam int QFULL_W     = RED_W + RECIP_W;
  localparam int RECIP_SHIFT = 29;
  localparam logic [RECIP_W-1:0] RECIP_125 = 23'd4294968;

  localparam logic signed [16:0] DAC_MAX     = 17'sd32767;
  localparam logic signed [16:0] DAC_MIN     = -17'sd32768;
  localparam logic [15:0]        DAC_MAX_W   = 16'h7FFF;
  localparam logic [15:0]        DAC_MIN_SAT = 16'h8001;

  typedef struct packed {
    logic spk;
    logic zero_gain;
    logic last;
  } stage_ctl_t;

  typedef struct packed {
    logic ld_prod;
    logic ld_quot;
    logic spk;
  } lane_ctl_t;

  function automatic logic [9:0] gain_of(input logic [3:0] idx);
    logic [9:0] g;
    case (idx)
      4'd0: g = 10'd0;
      4'd1: g = 10'd60;
      4'd2: g = 10'd125;
      4'd3: g = 10'd187;
      4'd4: g = 10'd250;
      4'd5: g = 10'd375;
      4'd6: g = 10'd500;
      4'd7: g = 10'd750;
      default: g = 10'd1000;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== sv/avdf_in_if.sv =====
`default_nettype none
interface avdf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic               frame_last;

  modport source (output valid, output left_sample, output right_sample, output frame_last,
                  input ready);
  modport sink (input valid, input left_sample, input right_sample, input frame_last,
                output ready);
endinterface
`default_nettype wire

// ===== sv/avdf_out_if.sv =====
`default_nettype none
interface avdf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_first;
  logic signed [15:0] out_second;
  logic               block_end;

  modport source (output valid, output out_first, output out_second, output block_end,
                  input ready);
  modport sink (input valid, input out_first, input out_second, input block_end,
                output ready);
endinterface
`default_nettype wire

// ===== sv/avdf_lane.sv =====
`default_nettype none
module avdf_lane (
  input  wire logic                            clk,
  input  wire logic [15:0]                     mag,
  input  wire logic                            neg,
  input  wire logic [avdf_pkg::COEF_W-1:0]     coef,
  input  wire avdf_pkg::lane_ctl_t             ctl,
  output logic [15:0]                          quot,
  output logic                                 quot_neg
);

  logic [avdf_pkg::PROD_W-1:0]  prod;
  logic                         prod_neg;
  logic [avdf_pkg::QFULL_W-1:0] qfull;
  logic [avdf_pkg::RED_W-1:0]   red;

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      prod     <= {{(avdf_pkg::PROD_W-16){1'b0}}, mag}
                * {{(avdf_pkg::PROD_W-avdf_pkg::COEF_W){1'b0}}, coef};
      prod_neg <= neg;
    end
  end

  // speaker: /2^15 then /8; dac: /8. Both leave /125.
  always_comb begin
    if (ctl.spk) begin
      red = {{(avdf_pkg::RED_W-16){1'b0}}, prod[33:18]};
    end else begin
      red = prod[24:3];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_quot) begin
      qfull    <= {{avdf_pkg::RECIP_W{1'b0}}, red}
                * {{avdf_pkg::RED_W{1'b0}}, avdf_pkg::RECIP_125};
      quot_neg <= prod_neg;
    end
  end

  assign quot = qfull[avdf_pkg::RECIP_SHIFT +: 16];

endmodule
`default_nettype wire

// ===== sv/avdf_format.sv =====
`default_nettype none
module avdf_format (
  input  wire logic [15:0]          q_a,
  input  wire logic                 neg_a,
  input  wire logic [15:0]          q_b,
  input  wire logic                 neg_b,
  input  wire avdf_pkg::stage_ctl_t ctl,
  output logic [15:0]               first,
  output logic [15:0]               second
);

  logic signed [16:0] val_a;
  logic signed [16:0] val_b;
  logic signed [8:0]  r;
  logic signed [8:0]  dac0;
  logic signed [8:0]  dac1;
  logic [7:0]         byte_first;
  logic [7:0]         byte_second;

  function automatic logic [15:0] dac_sat(input logic signed [16:0] v);
    logic [15:0] o;
    if (v > avdf_pkg::DAC_MAX) begin
      o = avdf_pkg::DAC_MAX_W;
    end else if (v < avdf_pkg::DAC_MIN) begin
      o = avdf_pkg::DAC_MIN_SAT;
    end else begin
      o = v[15:0];
    end
    return o;
  endfunction

  assign val_a = neg_a ? -$signed({1'b0, q_a}) : $signed({1'b0, q_a});
  assign val_b = neg_b ? -$signed({1'b0, q_b}) : $signed({1'b0, q_b});
  assign r     = val_a[8:0];

  always_comb begin
    if (r > 9'(avdf_pkg::SPK_HALF)) begin
      dac0 = 9'(avdf_pkg::SPK_HALF);
      dac1 = r - 9'(avdf_pkg::SPK_HALF);
    end else if (r < -9'(avdf_pkg::SPK_HALF)) begin
      dac0 = -9'(avdf_pkg::SPK_HALF);
      dac1 = r + 9'(avdf_pkg::SPK_HALF);
    end else begin
      dac0 = r;
      dac1 = 9'sd0;
    end
    byte_first  = avdf_pkg::SPK_BIAS - dac1[7:0];
    byte_second = dac0[7:0] + avdf_pkg::SPK_BIAS;
  end

  always_comb begin
    if (ctl.spk) begin
      if (ctl.zero_gain) begin
        first  = 16'h0000;
        second = 16'h0000;
      end else begin
        first  = {byte_first, 8'h00};
        second = {byte_second, 8'h00};
      end
    end else begin
      first  = dac_sat(val_a);
      second = dac_sat(val_b);
    end
  end

endmodule
`default_nettype wire

// ===== sv/audio_volume_dac_formatter_unit.sv =====
`default_nettype none
// Channel   Dir  Role             Payload
// samples   in   stereo frame     left_sample, right_sample, frame_last
// results   out  formatted words  out_first, out_second, block_end
// cfg_*     in   register write   cfg_index, cfg_data (no read-back)
//
// Four register stages: input, product, reciprocal product, output.
// One frame per cycle while the output is not stalled.
// Muted frames are accepted and dropped at the input stage.
// A stalled output holds; upstream stages keep filling until the pipe is full.
// rst (synchronous) empties the pipe and loads the register reset values.
module audio_volume_dac_formatter_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  avdf_in_if.sink         samples,
  avdf_out_if.source      results,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_index,
  input  wire logic [3:0] cfg_data
);

  logic [3:0] volume_level;
  logic       sink_mode;
  logic       muted;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy_out;
  logic accept;

  avdf_pkg::stage_ctl_t c1, c2, c3;
  avdf_pkg::lane_ctl_t  lctl;

  logic [15:0]                 mag_a, mag_b;
  logic                        neg_a, neg_b;
  logic [avdf_pkg::COEF_W-1:0] coef;

  logic [16:0]                 sum;
  logic signed [15:0]          avg;
  logic [15:0]                 in_mag_a, in_mag_b;
  logic                        in_neg_a;
  logic [3:0]                  idx;
  logic [9:0]                  gain;
  logic [avdf_pkg::COEF_W-1:0] in_coef;

  logic [15:0] q_a, q_b;
  logic        qneg_a, qneg_b;
  logic [15:0] fmt_first, fmt_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_level <= avdf_pkg::VOLUME_RESET;
      sink_mode    <= avdf_pkg::SINK_SPEAKER;
      muted        <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        avdf_pkg::REG_VOLUME: volume_level <= cfg_data;
        avdf_pkg::REG_SINK:   sink_mode    <= cfg_data[0];
        avdf_pkg::REG_MUTE:   muted        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign rdy_out       = !results.valid || results.ready;
  assign rdy3          = !v3 || rdy_out;
  assign rdy2          = !v2 || rdy3;
  assign rdy1          = !v1 || rdy2;
  assign samples.ready = rdy1;
  assign accept        = samples.valid && rdy1;

  assign sum      = {samples.left_sample[15], samples.left_sample}
                  + {samples.right_sample[15], samples.right_sample};
  assign avg      = sum[16:1];
  assign in_neg_a = (sink_mode == avdf_pkg::SINK_SPEAKER) ? avg[15] : samples.left_sample[15];
  assign idx      = (volume_level > avdf_pkg::GAIN_LAST_IDX) ? avdf_pkg::GAIN_LAST_IDX
                                                             : volume_level;
  assign gain     = avdf_pkg::gain_of(idx);

  always_comb begin
    if (sink_mode == avdf_pkg::SINK_SPEAKER) begin
      in_mag_a = avg[15] ? 16'(-avg) : avg;
      in_coef  = avdf_pkg::COEF_W'(avdf_pkg::SPK_MAGNITUDE * gain);
    end else begin
      in_mag_a = samples.left_sample[15] ? 16'(-samples.left_sample) : samples.left_sample;
      in_coef  = {{(avdf_pkg::COEF_W-10){1'b0}}, gain};
    end
    in_mag_b = samples.right_sample[15] ? 16'(-samples.right_sample) : samples.right_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= samples.valid && !muted;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy_out) begin
        results.valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mag_a        <= in_mag_a;
      neg_a        <= in_neg_a;
      mag_b        <= in_mag_b;
      neg_b        <= samples.right_sample[15];
      coef         <= in_coef;
      c1.spk       <= (sink_mode == avdf_pkg::SINK_SPEAKER);
      c1.zero_gain <= (gain == 10'd0);
      c1.last      <= samples.frame_last;
    end
    if (rdy2 && v1) begin
      c2 <= c1;
    end
    if (rdy3 && v2) begin
      c3 <= c2;
    end
    if (rdy_out && v3) begin
      results.out_first  <= fmt_first;
      results.out_second <= fmt_second;
      results.block_end  <= c3.last;
    end
  end

  assign lctl.ld_prod = rdy2 && v1;
  assign lctl.ld_quot = rdy3 && v2;
  assign lctl.spk     = c2.spk;

  avdf_lane u_lane_a (
    .clk      (clk),
    .mag      (mag_a),
    .neg      (neg_a),
    .coef     (coef),
    .ctl      (lctl),
    .quot     (q_a),
    .quot_neg (qneg_a)
  );

  avdf_lane u_lane_b (
    .clk      (clk),
    .mag      (mag_b),
    .neg      (neg_b),
    .coef     (coef),
    .ctl      (lctl),
    .quot     (q_b),
    .quot_neg (qneg_b)
  );

  avdf_format u_format (
    .q_a    (q_a),
    .neg_a  (qneg_a),
    .q_b    (q_b),
    .neg_b  (qneg_b),
    .ctl    (c3),
    .first  (fmt_first),
    .second (fmt_second)
  );

  a_mute_drop: assert property (@(posedge clk) disable iff (rst)
    accept && muted |=> !v1)
    else $error("muted transaction entered the pipe");

  a_spk_range: assert property (@(posedge clk) disable iff (rst)
    v3 && c3.spk |-> q_a <= 16'd254)
    else $error("speaker level out of range");

  a_dac_range: assert property (@(posedge clk) disable iff (rst)
    v3 && !c3.spk |-> (q_a <= 16'd32768) && (q_b <= 16'd32768))
    else $error("dac quotient out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready && v3 |=> v3)
    else $error("stage three lost a transaction under stall");

endmodule
`default_nettype wire

// ===== tb/audio_volume_dac_formatter_unit_tb.sv =====
`timescale 1ns / 100ps
module audio_volume_dac_formatter_unit_tb;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int GAIN_MILLI [9] = '{0, 60, 125, 187, 250, 375, 500, 750, 1000};
  localparam longint SPK_DIVISOR = 64'sd32768000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {FLOW_FREE, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH} flow_t;

  typedef struct packed {
    logic signed [15:0] first_word;
    logic signed [15:0] second_word;
    logic               block_end;
  } dac_words_t;

  class frame_scoreboard;
    logic [3:0] volume;
    logic       sink;
    logic       mute;
    dac_words_t expected[$];
    int mismatches;
    int checked;
    int dropped;
    int frames;

    function new();
      volume = avdf_pkg::VOLUME_RESET;
      sink = avdf_pkg::SINK_SPEAKER;
      mute = 1'b0;
      mismatches = 0;
      checked = 0;
      dropped = 0;
      frames = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [3:0] data);
      case (idx)
        avdf_pkg::REG_VOLUME: volume = data;
        avdf_pkg::REG_SINK: sink = data[0];
        avdf_pkg::REG_MUTE: mute = data[0];
        default: ;
      endcase
    endfunction

    function longint gain();
      return (volume > avdf_pkg::GAIN_LAST_IDX) ? longint'(GAIN_MILLI[8])
                                                : longint'(GAIN_MILLI[volume]);
    endfunction

    function logic [15:0] dac_word(logic signed [15:0] s, longint g);
      longint v;
      v = (longint'(s) * g) / 64'sd1000;
      if (v > 32767) v = 32767;
      else if (v < -32768) v = -32767;
      return 16'(v);
    endfunction

    function void note_frame(logic signed [15:0] left, logic signed [15:0] right, logic last);
      dac_words_t w;
      longint g;
      longint avg;
      longint level;
      longint dac0;
      longint dac1;
      frames++;
      if (mute) begin
        dropped++;
        return;
      end
      g = gain();
      w.block_end = last;
      if (sink == avdf_pkg::SINK_DAC) begin
        w.first_word = dac_word(left, g);
        w.second_word = dac_word(right, g);
      end else if (g == 0) begin
        w.first_word = '0;
        w.second_word = '0;
      end else begin
        avg = (longint'(left) + longint'(right)) >>> 1;
        level = (longint'(avdf_pkg::SPK_MAGNITUDE) * avg * g) / SPK_DIVISOR;
        if (level > avdf_pkg::SPK_HALF) begin
          dac0 = avdf_pkg::SPK_HALF;
          dac1 = level - avdf_pkg::SPK_HALF;
        end else if (level < -avdf_pkg::SPK_HALF) begin
          dac0 = -avdf_pkg::SPK_HALF;
          dac1 = level + avdf_pkg::SPK_HALF;
        end else begin
          dac0 = level;
          dac1 = 0;
        end
        w.first_word = {8'(avdf_pkg::SPK_BIAS - 8'(dac1)), 8'h00};
        w.second_word = {8'(8'(dac0) + avdf_pkg::SPK_BIAS), 8'h00};
      end
      expected.push_back(w);
    endfunction

    function void check_result(logic signed [15:0] first_word, logic signed [15:0] second_word,
                               logic block_end);
      dac_words_t w;
      if (expected.size() == 0) begin
        $error("unexpected result transaction: out_first %0d out_second %0d block_end %0b",
               first_word, second_word, block_end);
        mismatches++;
        return;
      end
      w = expected.pop_front();
      checked++;
      if (first_word !== w.first_word) begin
        $error("out_first expected %0d actual %0d", w.first_word, first_word);
        mismatches++;
      end
      if (second_word !== w.second_word) begin
        $error("out_second expected %0d actual %0d", w.second_word, second_word);
        mismatches++;
      end
      if (block_end !== w.block_end) begin
        $error("block_end expected %0b actual %0b", w.block_end, block_end);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;
  flow_t flow;
  int settings;

  avdf_in_if samples_ch();
  avdf_out_if results_ch();

  frame_scoreboard sb = new();

  audio_volume_dac_formatter_unit uut (
    .clk(clk),
    .rst(rst),
    .samples(samples_ch),
    .results(results_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function bit draw_gap(flow_t heavy);
    if (flow == heavy) return $urandom_range(99) < 77;
    if (flow == FLOW_BOTH) return $urandom_range(99) < 18;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    results_ch.ready <= !draw_gap(FLOW_SINK_STALLS);
  end

  always @(posedge clk) begin
    if (!rst && results_ch.valid && results_ch.ready)
      sb.check_result(results_ch.out_first, results_ch.out_second, results_ch.block_end);
  end

  task automatic write_reg(logic [1:0] idx, logic [3:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic write_setting(logic [3:0] vol, logic sink, logic mute);
    write_reg(avdf_pkg::REG_VOLUME, vol);
    write_reg(avdf_pkg::REG_SINK, {3'($urandom), sink});
    write_reg(avdf_pkg::REG_MUTE, {3'($urandom), mute});
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  task automatic send_frame(logic signed [15:0] left, logic signed [15:0] right, logic last);
    while (draw_gap(FLOW_SRC_GAPS)) begin
      samples_ch.valid <= 1'b0;
      @(posedge clk);
    end
    samples_ch.valid <= 1'b1;
    samples_ch.left_sample <= left;
    samples_ch.right_sample <= right;
    samples_ch.frame_last <= last;
    do @(posedge clk); while (!samples_ch.ready);
    sb.note_frame(left, right, last);
  endtask

  function logic signed [15:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(600)) - 300);
      3: return $urandom_range(1) ? 16'sh0000 : 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random();
    send_frame(rand_sample(), rand_sample(), $urandom_range(7) == 0);
  endtask

  task automatic drain();
    samples_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = avdf_pkg::REG_VOLUME;
    cfg_data = '0;
    samples_ch.valid = 1'b0;
    samples_ch.left_sample = '0;
    samples_ch.right_sample = '0;
    samples_ch.frame_last = 1'b0;
    flow = FLOW_FREE;
    settings = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset values of the registers
    send_frame(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_frame(16'sh8000, 16'sh8000, 1'b0);
    drain();

    // full gain speaker: both split directions and the rounding edges
    write_setting(4'd8, avdf_pkg::SINK_SPEAKER, 1'b0);
    send_frame(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_frame(16'sh8000, 16'sh8000, 1'b1);
    send_frame(16'sh0000, 16'sh0000, 1'b0);
    send_frame(16'shFFFF, 16'sh0000, 1'b0);
    send_frame(16'sh0001, 16'sh0000, 1'b0);
    send_frame(16'sh7FFF, 16'sh8000, 1'b1);
    drain();

    // zero gain speaker gives two zero words
    write_setting(4'd0, avdf_pkg::SINK_SPEAKER, 1'b0);
    send_frame(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_frame(16'sh8000, 16'sh0001, 1'b1);
    drain();

    // volume index beyond the table, external DAC
    write_setting(4'd15, avdf_pkg::SINK_DAC, 1'b0);
    send_frame(16'sh7FFF, 16'sh8000, 1'b0);
    send_frame(16'shFFFF, 16'sh0001, 1'b1);
    send_frame(16'sh8000, 16'sh7FFF, 1'b0);
    drain();

    write_setting(4'd0, avdf_pkg::SINK_DAC, 1'b0);
    send_frame(16'sh7FFF, 16'sh8000, 1'b1);
    drain();

    // muted frames vanish
    write_setting(4'd8, avdf_pkg::SINK_DAC, 1'b1);
    send_frame(16'sh7FFF, 16'sh8000, 1'b1);
    send_frame(16'sh1234, 16'sh8765, 1'b0);
    drain();

    // writes to the spare index are ignored
    write_setting(4'd5, avdf_pkg::SINK_SPEAKER, 1'b0);
    @(posedge clk);
    write_reg(REG_UNUSED, 4'hF);
    cfg_wr_en <= 1'b0;
    send_frame(16'sh7FFF, 16'sh4000, 1'b0);
    send_frame(16'shC000, 16'sh8000, 1'b1);
    drain();

    for (int p = 0; p < 32; p++) begin
      flow = flow_t'((p + p / 8) % 4);
      if (p % 8 == 5) begin
        write_setting(4'(p / 2), 1'(p % 2), 1'b1);
        repeat (16) send_random();
        drain();
      end
      write_setting(4'(p / 2), 1'(p % 2), 1'b0);
      repeat (64) send_random();
      drain();
    end

    $display("%0d frames over %0d register settings (all volumes, both sinks, mute)",
             sb.frames, settings);
    $display("%0d results checked, %0d muted frames dropped, %0d mismatches",
             sb.checked, sb.dropped, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/avdf_pkg.sv
sv/avdf_in_if.sv
sv/avdf_out_if.sv
sv/avdf_lane.sv
sv/avdf_format.sv
sv/audio_volume_dac_formatter_unit.sv
tb/audio_volume_dac_formatter_unit_tb.sv
